// ===== hdl/ier_pkg.sv =====
// ----------------------------------------------------------------------------
// ier_pkg
// shared types, constants and helpers for the icmp echo responder
// ----------------------------------------------------------------------------
package ier_pkg;

    // frame geometry
    localparam int FRAME_WORDS = 49;
    localparam int CNT_W       = 6;

    // word positions inside the buffered frame
    localparam logic [CNT_W-1:0] W_DMAC0    = 6'd0;
    localparam logic [CNT_W-1:0] W_DMAC1    = 6'd1;
    localparam logic [CNT_W-1:0] W_DMAC2    = 6'd2;
    localparam logic [CNT_W-1:0] W_SMAC0    = 6'd3;
    localparam logic [CNT_W-1:0] W_SMAC1    = 6'd4;
    localparam logic [CNT_W-1:0] W_SMAC2    = 6'd5;
    localparam logic [CNT_W-1:0] W_ETYPE    = 6'd6;
    localparam logic [CNT_W-1:0] W_VIHL     = 6'd7;
    localparam logic [CNT_W-1:0] W_TLEN     = 6'd8;
    localparam logic [CNT_W-1:0] W_ID       = 6'd9;
    localparam logic [CNT_W-1:0] W_FLAGS    = 6'd10;
    localparam logic [CNT_W-1:0] W_TTLPROTO = 6'd11;
    localparam logic [CNT_W-1:0] W_IPSUM    = 6'd12;
    localparam logic [CNT_W-1:0] W_SRCIP0   = 6'd13;
    localparam logic [CNT_W-1:0] W_SRCIP1   = 6'd14;
    localparam logic [CNT_W-1:0] W_DSTIP0   = 6'd15;
    localparam logic [CNT_W-1:0] W_DSTIP1   = 6'd16;
    localparam logic [CNT_W-1:0] W_ICMPTYPE = 6'd17;
    localparam logic [CNT_W-1:0] W_ICMPSUM  = 6'd18;
    localparam logic [CNT_W-1:0] W_PAYLOAD0 = 6'd19;
    localparam logic [CNT_W-1:0] W_LAST     = 6'(FRAME_WORDS - 1);
    localparam logic [CNT_W-1:0] W_FULL     = 6'(FRAME_WORDS);

    // header values a request must carry
    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [15:0] VIHL_PLAIN    = 16'h4500;
    localparam logic [15:0] TLEN_ECHO     = 16'h0054;
    localparam logic [7:0]  PROTO_ICMP    = 8'h01;
    localparam logic [15:0] ICMP_ECHO_REQ = 16'h0800;
    localparam logic [15:0] ICMP_ECHO_REP = 16'h0000;

    // configuration registers
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = 2'd1;
    localparam logic [47:0] LOCAL_MAC_RESET = 48'h0;
    localparam logic [31:0] LOCAL_IP_RESET  = 32'h0A00_0002;

    // checksum accumulator widths
    localparam int IPACC_W   = 20;
    localparam int ICMPACC_W = 21;

    // input and result words
    typedef struct packed {
        logic [15:0] frame_word;
        logic        frame_end;
    } t_in;

    typedef struct packed {
        logic [15:0] reply_word;
        logic        reply_end;
        logic        verdict;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic accept;     // store / capture an incoming word
        logic fold;       // evaluate checks, first checksum fold, rearm counters
        logic finish;     // second fold and inversion
        logic rd_first;   // start replay read at reply word zero
        logic emit;       // present the fetched reply word
        logic drop;       // present a drop result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic ok;         // frame passed every check
        logic last;       // word being emitted is the final one
    } t_dp_stat;

    // store address that feeds reply word k
    function automatic logic [CNT_W-1:0] reply_src(input logic [CNT_W-1:0] k);
        logic [CNT_W-1:0] a;
        a = k;
        case (k)
            W_DMAC0:  a = W_SMAC0;
            W_DMAC1:  a = W_SMAC1;
            W_DMAC2:  a = W_SMAC2;
            W_DSTIP0: a = W_SRCIP0;
            W_DSTIP1: a = W_SRCIP1;
            default:  a = k;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/ier_ctrl.sv =====
// ----------------------------------------------------------------------------
// ier_ctrl
// sequencer: receive words, check and fold, then replay or drop
// ----------------------------------------------------------------------------
module ier_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_frame_end,
    input  ier_pkg::t_dp_stat i_stat,
    output ier_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    localparam logic [1:0] S_RECV = 2'd0;
    localparam logic [1:0] S_FOLD = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_RECV: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_frame_end) begin
                        n_state = S_FOLD;
                    end
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.finish = 1'b1;
                if (i_stat.ok) begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_RECV;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.last) begin
                    n_state = S_RECV;
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    assign o_busy = (r_state != S_RECV);

endmodule

// ===== hdl/ier_dp.sv =====
// ----------------------------------------------------------------------------
// ier_dp
// datapath: frame store, header capture, checksum sums and reply mux
// ----------------------------------------------------------------------------
module ier_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ier_pkg::t_dp_cmd i_cmd,
    input  logic [15:0]      i_word,
    input  logic [47:0]      i_local_mac,
    input  logic [31:0]      i_local_ip,
    output ier_pkg::t_dp_stat o_stat,
    output logic             o_strobe,
    output ier_pkg::t_out    o_out
);

    logic [15:0] mem [ier_pkg::FRAME_WORDS];

    logic [ier_pkg::CNT_W-1:0]     r_count;
    logic [47:0]                   r_dmac;
    logic [15:0]                   r_etype;
    logic [15:0]                   r_vihl;
    logic [15:0]                   r_tlen;
    logic [7:0]                    r_proto;
    logic [31:0]                   r_dip;
    logic [15:0]                   r_icmp;
    logic [ier_pkg::IPACC_W-1:0]   r_ip_acc;
    logic [ier_pkg::ICMPACC_W-1:0] r_icmp_acc;
    logic                          r_ok;
    logic [16:0]                   r_ip_s1;
    logic [16:0]                   r_icmp_s1;
    logic [15:0]                   r_ipsum;
    logic [15:0]                   r_icmpsum;
    logic [15:0]                   r_mem_q;
    logic [ier_pkg::CNT_W-1:0]     r_q_idx;
    logic [ier_pkg::CNT_W-1:0]     r_next;
    logic                          r_strobe;
    ier_pkg::t_out                 r_out;

    logic                          store_en;
    logic [ier_pkg::IPACC_W-1:0]   ip_total;
    logic [16:0]                   ip_s2;
    logic [16:0]                   icmp_s2;
    logic                          checks_ok;
    logic [15:0]                   reply_word;

    assign store_en = i_cmd.accept && (r_count < ier_pkg::W_FULL);

    // frame store write
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            mem[r_count] <= i_word;
        end
    end

    // word count and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ip_acc   <= '0;
            r_icmp_acc <= '0;
        end else if (i_cmd.fold) begin
            r_count    <= '0;
            r_ip_acc   <= '0;
            r_icmp_acc <= '0;
        end else if (store_en) begin
            r_count <= r_count + 1'b1;
            case (r_count) inside
                ier_pkg::W_VIHL, ier_pkg::W_TLEN, ier_pkg::W_TTLPROTO,
                ier_pkg::W_SRCIP0, ier_pkg::W_SRCIP1: begin
                    r_ip_acc <= r_ip_acc + ier_pkg::IPACC_W'(i_word);
                end
                [ier_pkg::W_PAYLOAD0:ier_pkg::W_LAST]: begin
                    r_icmp_acc <= r_icmp_acc + ier_pkg::ICMPACC_W'(i_word);
                end
                default: begin
                end
            endcase
        end
    end

    // header fields needed by the checks
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            case (r_count)
                ier_pkg::W_DMAC0:    r_dmac[47:32] <= i_word;
                ier_pkg::W_DMAC1:    r_dmac[31:16] <= i_word;
                ier_pkg::W_DMAC2:    r_dmac[15:0]  <= i_word;
                ier_pkg::W_ETYPE:    r_etype       <= i_word;
                ier_pkg::W_VIHL:     r_vihl        <= i_word;
                ier_pkg::W_TLEN:     r_tlen        <= i_word;
                ier_pkg::W_TTLPROTO: r_proto       <= i_word[7:0];
                ier_pkg::W_DSTIP0:   r_dip[31:16]  <= i_word;
                ier_pkg::W_DSTIP1:   r_dip[15:0]   <= i_word;
                ier_pkg::W_ICMPTYPE: r_icmp        <= i_word;
                default: begin
                end
            endcase
        end
    end

    // request checks
    assign checks_ok = (r_count == ier_pkg::W_FULL)
                    && (r_dmac == i_local_mac)
                    && (r_etype == ier_pkg::ETYPE_IPV4)
                    && (r_vihl == ier_pkg::VIHL_PLAIN)
                    && (r_tlen == ier_pkg::TLEN_ECHO)
                    && (r_proto == ier_pkg::PROTO_ICMP)
                    && (r_dip == i_local_ip)
                    && (r_icmp == ier_pkg::ICMP_ECHO_REQ);

    // ip header sum gets the new source address
    assign ip_total = r_ip_acc + ier_pkg::IPACC_W'(i_local_ip[31:16])
                               + ier_pkg::IPACC_W'(i_local_ip[15:0]);

    assign ip_s2   = {1'b0, r_ip_s1[15:0]} + 17'(r_ip_s1[16]);
    assign icmp_s2 = {1'b0, r_icmp_s1[15:0]} + 17'(r_icmp_s1[16]);

    // checksum folding in two steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.fold) begin
            r_ip_s1   <= {1'b0, ip_total[15:0]} + 17'(ip_total[ier_pkg::IPACC_W-1:16]);
            r_icmp_s1 <= {1'b0, r_icmp_acc[15:0]}
                       + 17'(r_icmp_acc[ier_pkg::ICMPACC_W-1:16]);
        end
        if (i_cmd.finish) begin
            r_ipsum   <= ~ip_s2[15:0];
            r_icmpsum <= ~icmp_s2[15:0];
        end
    end

    // verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= 1'b0;
        end else if (i_cmd.fold) begin
            r_ok <= checks_ok;
        end
    end

    // replay read, one word ahead of the output
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_first) begin
            r_mem_q <= mem[ier_pkg::reply_src('0)];
            r_q_idx <= '0;
            r_next  <= 6'd1;
        end else if (i_cmd.emit) begin
            if (r_next < ier_pkg::W_FULL) begin
                r_mem_q <= mem[ier_pkg::reply_src(r_next)];
            end
            r_q_idx <= r_next;
            r_next  <= r_next + 1'b1;
        end
    end

    // reply word substitution
    always_comb begin
        case (r_q_idx)
            ier_pkg::W_SMAC0:    reply_word = i_local_mac[47:32];
            ier_pkg::W_SMAC1:    reply_word = i_local_mac[31:16];
            ier_pkg::W_SMAC2:    reply_word = i_local_mac[15:0];
            ier_pkg::W_ID:       reply_word = '0;
            ier_pkg::W_FLAGS:    reply_word = '0;
            ier_pkg::W_IPSUM:    reply_word = r_ipsum;
            ier_pkg::W_SRCIP0:   reply_word = i_local_ip[31:16];
            ier_pkg::W_SRCIP1:   reply_word = i_local_ip[15:0];
            ier_pkg::W_ICMPTYPE: reply_word = ier_pkg::ICMP_ECHO_REP;
            ier_pkg::W_ICMPSUM:  reply_word = r_icmpsum;
            default:             reply_word = r_mem_q;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit || i_cmd.drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drop) begin
            r_out.reply_word <= '0;
            r_out.reply_end  <= 1'b1;
            r_out.verdict    <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out.reply_word <= reply_word;
            r_out.reply_end  <= (r_q_idx == ier_pkg::W_LAST);
            r_out.verdict    <= 1'b0;
        end
    end

    assign o_stat.ok   = r_ok;
    assign o_stat.last = (r_q_idx == ier_pkg::W_LAST);
    assign o_strobe    = r_strobe;
    assign o_out       = r_out;

endmodule

// ===== hdl/icmp_echo_responder.sv =====
// ----------------------------------------------------------------------------
// icmp_echo_responder
// answers icmp echo requests carried in ethernet frames of 16-bit words
// ----------------------------------------------------------------------------
// channel   direction  handshake            word
// input     in         i_start / o_busy     i_in  (frame_word, frame_end)
// result    out        o_strobe (no stall)  o_out (reply_word, reply_end, verdict)
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// one word is taken per cycle while o_busy is low; the final word of a frame
// starts checking and checksum folding in states S_FOLD and S_SUM, then a good
// request is replayed as 49 result words on consecutive cycles, one store read
// each. reset is synchronous and clears the word count, sums, verdict, result
// strobe, configuration registers and sequencer, not the store.
// results cannot be held off: each strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
module icmp_echo_responder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  ier_pkg::t_in                        i_in,
    output logic                                o_strobe,
    output ier_pkg::t_out                       o_out,
    input  logic                                i_cfg_we,
    input  logic [ier_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ier_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [47:0]       r_local_mac;
    logic [31:0]       r_local_ip;
    ier_pkg::t_dp_cmd  cmd;
    ier_pkg::t_dp_stat stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mac <= ier_pkg::LOCAL_MAC_RESET;
            r_local_ip  <= ier_pkg::LOCAL_IP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ier_pkg::CFG_LOCAL_MAC: r_local_mac <= i_cfg_data[47:0];
                ier_pkg::CFG_LOCAL_IP:  r_local_ip  <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    ier_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_frame_end (i_in.frame_end),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (o_busy)
    );

    // datapath
    ier_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_word      (i_in.frame_word),
        .i_local_mac (r_local_mac),
        .i_local_ip  (r_local_ip),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_out       (o_out)
    );

endmodule

// ===== dv/tb_icmp_echo_responder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_icmp_echo_responder
// self-checking bench for the icmp echo responder: frames are sent as
// 16-bit words, and a behavioral copy of the block predicts the reply words
// or the drop word for each frame. results are compared in order against
// that prediction. coverage comes from directed header, checksum, length and
// register cases, then random traffic that is mostly well-formed echo requests.
// ----------------------------------------------------------------------------
module tb_icmp_echo_responder;
    import ier_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int BUF_WORDS    = 80;
    localparam int RANDOM_WORDS = 500;
    localparam int MAX_REPORTS  = 10;

    // register indexes past the end of the list, the block ignores them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // one header check to break in a request
    typedef enum int {
        BRK_DMAC, BRK_ETYPE, BRK_VERSION, BRK_TOS, BRK_TLEN,
        BRK_PROTO, BRK_DIP, BRK_TYPE, BRK_CODE
    } t_break;

    // filler for the words a request leaves free
    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} t_fill;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_in         i_in;
    logic        o_strobe;
    t_out        o_out;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predictor state
    logic [47:0] cfg_mac;
    logic [31:0] cfg_ip;
    logic [15:0] rx_store [0:FRAME_WORDS-1];
    int          rx_count;
    logic        rx_full;
    logic [15:0] echo_buf [0:FRAME_WORDS-1];
    t_out        exp_reply_q [$];

    // stimulus state
    logic [15:0] frame_buf [0:BUF_WORDS-1];
    logic        gaps_allowed;
    logic        gaps_now;
    int          words_sent;
    int          err_count;
    int          cycle_count;

    icmp_echo_responder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_strobe    (o_strobe),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    // ones-complement checksum over echo_buf[first..last], carries folded fully
    function automatic logic [15:0] echo_csum(input int first, input int last);
        logic [31:0] acc;
        acc = '0;
        for (int k = first; k <= last; k++)
            acc += {16'h0, echo_buf[k]};
        while (acc[31:16] != 16'h0)
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        return ~acc[15:0];
    endfunction

    // header checks on the buffered frame
    function automatic logic request_valid();
        return {rx_store[W_DMAC0], rx_store[W_DMAC1], rx_store[W_DMAC2]} == cfg_mac
            && rx_store[W_ETYPE] == ETYPE_IPV4
            && rx_store[W_VIHL] == VIHL_PLAIN
            && rx_store[W_TLEN] == TLEN_ECHO
            && rx_store[W_TTLPROTO][7:0] == PROTO_ICMP
            && {rx_store[W_DSTIP0], rx_store[W_DSTIP1]} == cfg_ip
            && rx_store[W_ICMPTYPE] == ICMP_ECHO_REQ;
    endfunction

    // take one accepted word, queue the reply or drop word at frame end
    task automatic predict_echo(input t_in item);
        t_out res;
        logic pass;
        if (!rx_full && rx_count < FRAME_WORDS) begin
            rx_store[rx_count] = item.frame_word;
            rx_count++;
            if (rx_count >= FRAME_WORDS)
                rx_full = 1'b1;
        end
        if (!item.frame_end)
            return;
        pass = rx_full && request_valid();
        rx_count = 0;
        rx_full = 1'b0;
        if (!pass) begin
            res.reply_word = 16'h0;
            res.reply_end = 1'b1;
            res.verdict = 1'b1;
            exp_reply_q.push_back(res);
            return;
        end
        // swap addresses, clear id and flags, rebuild both checksums
        for (int k = 0; k < FRAME_WORDS; k++)
            echo_buf[k] = rx_store[k];
        echo_buf[W_DMAC0] = rx_store[W_SMAC0];
        echo_buf[W_DMAC1] = rx_store[W_SMAC1];
        echo_buf[W_DMAC2] = rx_store[W_SMAC2];
        echo_buf[W_SMAC0] = cfg_mac[47:32];
        echo_buf[W_SMAC1] = cfg_mac[31:16];
        echo_buf[W_SMAC2] = cfg_mac[15:0];
        echo_buf[W_ID] = 16'h0;
        echo_buf[W_FLAGS] = 16'h0;
        echo_buf[W_SRCIP0] = cfg_ip[31:16];
        echo_buf[W_SRCIP1] = cfg_ip[15:0];
        echo_buf[W_DSTIP0] = rx_store[W_SRCIP0];
        echo_buf[W_DSTIP1] = rx_store[W_SRCIP1];
        echo_buf[W_IPSUM] = 16'h0;
        echo_buf[W_IPSUM] = echo_csum(W_VIHL, W_DSTIP1);
        echo_buf[W_ICMPTYPE] = ICMP_ECHO_REP;
        echo_buf[W_ICMPSUM] = 16'h0;
        echo_buf[W_ICMPSUM] = echo_csum(W_ICMPTYPE, W_LAST);
        for (int k = 0; k < FRAME_WORDS; k++) begin
            res.reply_word = echo_buf[k];
            res.reply_end = (k == FRAME_WORDS - 1);
            res.verdict = 1'b0;
            exp_reply_q.push_back(res);
        end
    endtask

    // result checker, results cannot be stalled
    always @(posedge i_clk) begin : chk_results
        t_out want;
        if (i_rst_n && o_strobe) begin
            if (exp_reply_q.size() == 0) begin
                note_error($sformatf("unexpected word %h end %b verdict %b",
                    o_out.reply_word, o_out.reply_end, o_out.verdict));
            end else begin
                want = exp_reply_q.pop_front();
                if (o_out.reply_word !== want.reply_word
                        || o_out.reply_end !== want.reply_end
                        || o_out.verdict !== want.verdict)
                    note_error($sformatf("expected %h/%b/%b got %h/%b/%b",
                        want.reply_word, want.reply_end, want.verdict,
                        o_out.reply_word, o_out.reply_end, o_out.verdict));
            end
        end
    end

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_start = 1'b0;
        end
    endtask

    // offer one word and hold it until the block takes it
    task automatic send_word(input logic [15:0] w, input logic last);
        t_in item;
        if (gaps_now && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 5));
        item.frame_word = w;
        item.frame_end = last;
        @(negedge i_clk);
        i_start = 1'b1;
        i_in = item;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        words_sent++;
        predict_echo(item);
    endtask

    task automatic send_frame(input int len);
        gaps_now = gaps_allowed && ($urandom_range(0, 2) != 0);
        for (int k = 0; k < len; k++)
            send_word(frame_buf[k], k == len - 1);
    endtask

    // stop offering words and let every expected result come out
    task automatic wait_idle(input int settle);
        int spin;
        spin = 0;
        @(negedge i_clk);
        i_start = 1'b0;
        while (exp_reply_q.size() != 0 && spin < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_LOCAL_MAC: cfg_mac = data[47:0];
            CFG_LOCAL_IP:  cfg_ip = data[31:0];
            default: ;
        endcase
    endtask

    // well-formed echo request to the given addresses
    task automatic build_request(input logic [47:0] dmac, input logic [31:0] dip,
                                 input t_fill fill);
        for (int k = 0; k < BUF_WORDS; k++) begin
            case (fill)
                FILL_ONES:  frame_buf[k] = 16'hffff;
                FILL_ZEROS: frame_buf[k] = 16'h0000;
                default:    frame_buf[k] = 16'($urandom);
            endcase
        end
        frame_buf[W_DMAC0] = dmac[47:32];
        frame_buf[W_DMAC1] = dmac[31:16];
        frame_buf[W_DMAC2] = dmac[15:0];
        frame_buf[W_ETYPE] = ETYPE_IPV4;
        frame_buf[W_VIHL] = VIHL_PLAIN;
        frame_buf[W_TLEN] = TLEN_ECHO;
        frame_buf[W_TTLPROTO][7:0] = PROTO_ICMP;
        frame_buf[W_DSTIP0] = dip[31:16];
        frame_buf[W_DSTIP1] = dip[15:0];
        frame_buf[W_ICMPTYPE] = ICMP_ECHO_REQ;
    endtask

    // flip one bit inside the field that a given check looks at
    task automatic break_check(input t_break which);
        logic [15:0] lo_bit;
        logic [15:0] hi_bit;
        logic [15:0] any_bit;
        lo_bit = 16'h1 << $urandom_range(0, 7);
        hi_bit = 16'h1 << $urandom_range(8, 15);
        any_bit = 16'h1 << $urandom_range(0, 15);
        case (which)
            BRK_DMAC:    frame_buf[$urandom_range(0, 2)] ^= any_bit;
            BRK_ETYPE:   frame_buf[W_ETYPE] ^= any_bit;
            BRK_VERSION: frame_buf[W_VIHL] ^= hi_bit;
            BRK_TOS:     frame_buf[W_VIHL] ^= lo_bit;
            BRK_TLEN:    frame_buf[W_TLEN] ^= any_bit;
            BRK_PROTO:   frame_buf[W_TTLPROTO] ^= lo_bit;
            BRK_DIP:     frame_buf[$urandom_range(W_DSTIP0, W_DSTIP1)] ^= any_bit;
            BRK_TYPE:    frame_buf[W_ICMPTYPE] ^= hi_bit;
            default:     frame_buf[W_ICMPTYPE] ^= lo_bit;
        endcase
    endtask

    // a request to the reset addresses, no register written yet
    task automatic test_reset_config();
        build_request(cfg_mac, cfg_ip, FILL_RANDOM);
        send_frame(FRAME_WORDS);
    endtask

    // free words all ones then all zeros, worst and best case carries
    task automatic test_checksum_extremes();
        build_request(cfg_mac, cfg_ip, FILL_ONES);
        send_frame(FRAME_WORDS);
        build_request(cfg_mac, cfg_ip, FILL_ZEROS);
        send_frame(FRAME_WORDS);
    endtask

    // each header check broken alone, plus ttl which is not checked
    task automatic test_header_checks();
        wait_idle(4);
        write_cfg(CFG_LOCAL_MAC, 48'h0250_a1b2_c3d4);
        write_cfg(CFG_LOCAL_IP, 48'h0000_c0a8_0107);
        for (int b = BRK_DMAC; b <= BRK_CODE; b++) begin
            build_request(cfg_mac, cfg_ip, FILL_RANDOM);
            break_check(t_break'(b));
            send_frame(FRAME_WORDS);
        end
        build_request(cfg_mac, cfg_ip, FILL_RANDOM);
        frame_buf[W_TTLPROTO][15:8] = 8'hff;
        send_frame(FRAME_WORDS);
    endtask

    // single word frame, one word short, one word over, and overlong frames
    task automatic test_frame_lengths();
        build_request(cfg_mac, cfg_ip, FILL_RANDOM);
        send_frame(1);
        build_request(cfg_mac, cfg_ip, FILL_RANDOM);
        send_frame(FRAME_WORDS - 1);
        build_request(cfg_mac, cfg_ip, FILL_RANDOM);
        send_frame(FRAME_WORDS + 1);
        build_request(cfg_mac, cfg_ip, FILL_RANDOM);
        send_frame(BUF_WORDS);
    endtask

    // register extremes, ip data wider than the register, spare indexes
    task automatic test_config_registers();
        wait_idle(4);
        write_cfg(CFG_LOCAL_MAC, 48'hffff_ffff_ffff);
        write_cfg(CFG_LOCAL_IP, 48'hffff_ffff_ffff);
        build_request(cfg_mac, cfg_ip, FILL_RANDOM);
        send_frame(FRAME_WORDS);
        wait_idle(4);
        write_cfg(CFG_LOCAL_MAC, 48'h0);
        write_cfg(CFG_LOCAL_IP, 48'h0);
        build_request(cfg_mac, cfg_ip, FILL_ONES);
        send_frame(FRAME_WORDS);
        wait_idle(4);
        write_cfg(CFG_LOCAL_MAC, 48'h8000_0000_0001);
        write_cfg(CFG_LOCAL_IP, 48'h5a5a_8000_0001);
        write_cfg(CFG_SPARE_A, {16'($urandom), 32'($urandom)});
        write_cfg(CFG_SPARE_B, {16'($urandom), 32'($urandom)});
        build_request(cfg_mac, cfg_ip, FILL_RANDOM);
        send_frame(FRAME_WORDS);
    endtask

    // mostly good requests, some broken, short, noisy and overlong frames
    task automatic test_random_traffic();
        int first_word;
        int pick;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 3)
                gaps_allowed = 1'b0;
            wait_idle(4);
            write_cfg(CFG_LOCAL_MAC, {16'($urandom), 32'($urandom)});
            write_cfg(CFG_LOCAL_IP, {16'($urandom), 32'($urandom)});
            first_word = words_sent;
            while (words_sent - first_word < RANDOM_WORDS / 4) begin
                pick = $urandom_range(0, 99);
                build_request(cfg_mac, cfg_ip, FILL_RANDOM);
                if (pick < 55) begin
                    send_frame(FRAME_WORDS);
                end else if (pick < 75) begin
                    break_check(t_break'($urandom_range(BRK_DMAC, BRK_CODE)));
                    send_frame(FRAME_WORDS);
                end else if (pick < 85) begin
                    if (pick < 80)
                        build_request(48'h0, 32'h0, FILL_RANDOM);
                    send_frame($urandom_range(1, FRAME_WORDS - 1));
                end else if (pick < 95) begin
                    // pure noise, content unrelated to any header
                    for (int k = 0; k < BUF_WORDS; k++)
                        frame_buf[k] = 16'($urandom);
                    send_frame($urandom_range(FRAME_WORDS, BUF_WORDS));
                end else begin
                    send_frame($urandom_range(FRAME_WORDS + 1, BUF_WORDS));
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cfg_mac = LOCAL_MAC_RESET;
        cfg_ip = LOCAL_IP_RESET;
        rx_count = 0;
        rx_full = 1'b0;
        gaps_allowed = 1'b1;
        gaps_now = 1'b0;
        words_sent = 0;
        err_count = 0;
        cycle_count = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_config();
        test_checksum_extremes();
        test_header_checks();
        test_frame_lengths();
        test_config_registers();
        test_random_traffic();

        // drain, then watch a while for stray results
        wait_idle(60);
        if (exp_reply_q.size() != 0)
            note_error($sformatf("%0d result words never arrived", exp_reply_q.size()));
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ier_pkg.sv
hdl/ier_ctrl.sv
hdl/ier_dp.sv
hdl/icmp_echo_responder.sv
dv/tb_icmp_echo_responder.sv
